[src/assert_macros.svh]
// Assertion macros shared by the drive block RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

[src/sscd_pkg.sv]
// Shared types and constants for the stereo soft clip drive block.
// No dependencies; used by sscd_chan and stereo_soft_clip_drive_top.
package sscd_pkg;

	localparam int GAIN_W    = 24;
	localparam int REG_IDX_W = 2;
	localparam int DIV_STEPS = 32;
	// sample in to sample out of one channel pipeline, in enabled cycles
	localparam int CHAN_LAT  = 21 + DIV_STEPS;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TRIM_GAIN   = 2'd0,
		REG_DRIVE_GAIN  = 2'd1,
		REG_MAKEUP_GAIN = 2'd2,
		REG_OUT_GAIN    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] trim_gain;
		logic [GAIN_W-1:0] drive_gain;
		logic [GAIN_W-1:0] makeup_gain;
		logic [GAIN_W-1:0] out_gain;
	} gains_t;

	localparam logic [GAIN_W-1:0] TRIM_GAIN_RST   = 24'd4096;
	localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST  = 24'd0;
	localparam logic [GAIN_W-1:0] MAKEUP_GAIN_RST = 24'd12811;
	localparam logic [GAIN_W-1:0] OUT_GAIN_RST    = 24'd4096;

	// Q30 constants of the clipper core
	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF  = 31'h2000_0000;
	localparam logic [32:0] Q30_THREE = 33'h0_C000_0000;
	// floor(m/3) = (m * RECIP3) >> 33 for any 32-bit m
	localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;

endpackage

[src/stereo_soft_clip_drive_top.sv]
// Channel  Handshake              Payload
// in       in_valid / in_stall    left_sample, right_sample, block_end
// out      out_valid / out_stall  left_out, right_out, block_end_out
// config   wr_en                  wr_index, wr_data
//
// One frame enters per cycle while in_stall is low; its result shows on out_valid after the
// 53 channel stages (33 of them the bit-per-stage clipper divider) and then the output
// register; the first stage loads on the edge that takes the frame.
// Reset clears the stage valid bits, the output and skid valid bits and loads the
// default gains.
// A stalled output parks one more result in the skid register; in_stall then holds
// the whole pipeline until the output is taken.
`include "assert_macros.svh"

module stereo_soft_clip_drive_top import sscd_pkg::*; #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          block_end,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          block_end_out,

	input  logic                          wr_en,
	input  logic [REG_IDX_W-1:0]          wr_index,
	input  logic [GAIN_W-1:0]             wr_data
);

	gains_t                 gains_q;
	logic                   pipe_en;
	logic [CHAN_LAT:1]      vld_s;
	logic [CHAN_LAT:1]      last_s;
	logic [SAMPLE_BITS-1:0] left_pipe, right_pipe;

	logic                   out_v_q, skid_v_q;
	logic [SAMPLE_BITS-1:0] left_q, right_q, skid_left_q, skid_right_q;
	logic                   last_q, skid_last_q;
	logic                   take, load_out, skid_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.trim_gain   <= TRIM_GAIN_RST;
			gains_q.drive_gain  <= DRIVE_GAIN_RST;
			gains_q.makeup_gain <= MAKEUP_GAIN_RST;
			gains_q.out_gain    <= OUT_GAIN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TRIM_GAIN:   gains_q.trim_gain   <= wr_data;
				REG_DRIVE_GAIN:  gains_q.drive_gain  <= wr_data;
				REG_MAKEUP_GAIN: gains_q.makeup_gain <= wr_data;
				REG_OUT_GAIN:    gains_q.out_gain    <= wr_data;
				default: ;
			endcase
		end
	end

	assign pipe_en  = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (pipe_en) begin
			vld_s <= {vld_s[CHAN_LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			last_s <= {last_s[CHAN_LAT-1:1], block_end};
		end
	end

	sscd_chan #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_left (
		.clk    (clk),
		.en     (pipe_en),
		.gains  (gains_q),
		.sample (left_sample),
		.driven (left_pipe)
	);

	sscd_chan #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_right (
		.clk    (clk),
		.en     (pipe_en),
		.gains  (gains_q),
		.sample (right_sample),
		.driven (right_pipe)
	);

	// output register with one skid entry behind it
	assign take      = out_v_q && !out_stall;
	assign load_out  = pipe_en && vld_s[CHAN_LAT] && (!out_v_q || take);
	assign skid_load = pipe_en && vld_s[CHAN_LAT] && out_v_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				skid_v_q <= !take;
			end else begin
				skid_v_q <= skid_load;
			end
			if (!skid_v_q) begin
				if (vld_s[CHAN_LAT]) begin
					out_v_q <= 1'b1;
				end else if (take) begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q && take) begin
			left_q  <= skid_left_q;
			right_q <= skid_right_q;
			last_q  <= skid_last_q;
		end else if (load_out) begin
			left_q  <= left_pipe;
			right_q <= right_pipe;
			last_q  <= last_s[CHAN_LAT];
		end
		if (skid_load) begin
			skid_left_q  <= left_pipe;
			skid_right_q <= right_pipe;
			skid_last_q  <= last_s[CHAN_LAT];
		end
	end

	assign out_valid     = out_v_q;
	assign left_out      = left_q;
	assign right_out     = right_q;
	assign block_end_out = last_q;

	`ASSERT_NEVER(a_skid_without_out, skid_v_q && !out_v_q, "skid item held with output empty")
	`ASSERT_CLK(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && out_stall), "early skid fill")
	`ASSERT_CLK(a_pipe_hold, in_stall |=> $stable(vld_s), "pipeline moved while input stalled")

endmodule

[src/sscd_chan.sv]
// One channel of the soft clip drive: gain, rational clipper, makeup gain, saturation.
// Depends on sscd_pkg. The pipeline advances only when en is high.
module sscd_chan import sscd_pkg::*; #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          en,
	input  gains_t                        gains,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] driven
);

	localparam int F        = SAMPLE_BITS - 1;
	localparam int G        = GAIN_FRAC_BITS;
	localparam int MW       = SAMPLE_BITS;
	localparam int PW1      = MW + GAIN_W;
	localparam int XW       = F + 2;
	localparam int L1W      = F + 2 + G;
	localparam int L1LO     = L1W / 2;
	localparam int L1HI     = L1W - L1LO;
	localparam int PPW1     = L1W + GAIN_W;
	localparam int L2W      = F + G + 1;
	localparam int L2LO     = L2W / 2;
	localparam int L2HI     = L2W - L2LO;
	localparam int PPW2     = L2W + GAIN_W;
	localparam int DIV_LAST = 14 + DIV_STEPS;

	localparam logic [MW-1:0]   ONE_Q   = {1'b1, {F{1'b0}}};
	localparam logic [XW-1:0]   THREE_Q = {2'b11, {F{1'b0}}};
	localparam logic [XW-1:0]   CAP1    = THREE_Q + XW'(1);
	localparam logic [L1W-1:0]  LIM1P   = {CAP1, {G{1'b0}}} + L1W'(1);
	localparam logic [L2W-1:0]  LIM2P   = {1'b1, {(F + G){1'b0}}} + L2W'(1);
	localparam logic [PW1:0]    RND1    = (PW1 + 1)'(1) << (G - 1);
	localparam logic [PPW1:0]   RNDP1   = (PPW1 + 1)'(1) << (G - 1);
	localparam logic [PPW2:0]   RNDP2   = (PPW2 + 1)'(1) << (G - 1);

	logic [CHAN_LAT-1:1]   neg_s;
	logic [DIV_LAST:7]     over_s;

	logic [MW-1:0]         samp_u;
	logic [MW-1:0]         mag_s1;
	logic [PW1-1:0]        pin_s2;
	logic [PW1:0]          p1_sum;
	logic [PW1-G:0]        p1_rnd;
	logic [L1W-1:0]        p1_s3;
	logic [L1LO+GAIN_W-1:0] pplo_s4;
	logic [L1HI+GAIN_W-1:0] pphi_s4;
	logic [PPW1-1:0]       ppre_s5;
	logic [PPW1:0]         x_sum;
	logic [PPW1-G:0]       x_rnd;
	logic [XW-1:0]         x_s6;
	logic [33:0]           mx;
	logic [31:0]           m_s7;
	logic [63:0]           rp_s8;
	logic [30:0]           t_s9, t_s10, t_s11, t_s12;
	logic [61:0]           tsq_s10;
	logic [61:0]           tsq_rnd;
	logic [30:0]           t2_s11;
	logic [32:0]           a_s12, den_s12, den_s13;
	logic [62:0]           num_s13;
	logic [62:0]           nn;

	// entry k of the divider arrays is stage s14+k
	logic [32:0]           div_rem_s14 [0:DIV_STEPS];
	logic [31:0]           div_quo_s14 [0:DIV_STEPS];
	logic [31:0]           div_num_s14 [0:DIV_STEPS-1];
	logic [32:0]           div_den_s14 [0:DIV_STEPS-1];

	logic [31:0]           quo;
	logic [30:0]           y30;
	logic [MW-1:0]         y_conv;
	logic [MW-1:0]         y_s47;
	logic [PW1-1:0]        ppost_s48;
	logic [PW1:0]          p2_sum;
	logic [PW1-G:0]        p2_rnd;
	logic [L2W-1:0]        p2_s49;
	logic [L2LO+GAIN_W-1:0] pp2lo_s50;
	logic [L2HI+GAIN_W-1:0] pp2hi_s50;
	logic [PPW2-1:0]       plev_s51;
	logic [PPW2:0]         q_sum;
	logic [PPW2-G:0]       q_rnd;
	logic [MW-1:0]         q_s52;
	logic [MW-1:0]         out_s53;

	assign samp_u = sample;
	assign p1_sum = (PW1 + 1)'(pin_s2) + RND1;
	assign p1_rnd = p1_sum[PW1:G];
	assign x_sum  = (PPW1 + 1)'(ppre_s5) + RNDP1;
	assign x_rnd  = x_sum[PPW1:G];
	assign mx     = (34'(x_s6) << (31 - F)) + 34'd3;
	assign tsq_rnd = tsq_s10 + 62'(Q30_HALF);
	assign nn     = num_s13 + 63'(den_s13[32:1]);

	// gain front end and clipper setup
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s   <= {neg_s[CHAN_LAT-2:1], samp_u[F]};
			over_s  <= {over_s[DIV_LAST-1:7], (x_s6 > THREE_Q)};
			mag_s1  <= samp_u[F] ? (~samp_u + MW'(1)) : samp_u;
			pin_s2  <= mag_s1 * gains.trim_gain;
			p1_s3   <= (p1_rnd > LIM1P) ? LIM1P : L1W'(p1_rnd);
			pplo_s4 <= p1_s3[L1LO-1:0] * gains.drive_gain;
			pphi_s4 <= p1_s3[L1W-1:L1LO] * gains.drive_gain;
			ppre_s5 <= PPW1'(pplo_s4) + (PPW1'(pphi_s4) << L1LO);
			x_s6    <= (x_rnd > CAP1) ? CAP1 : XW'(x_rnd);
			m_s7    <= mx[32:1];
			rp_s8   <= m_s7 * RECIP3;
			t_s9    <= (rp_s8[63:33] > Q30_ONE) ? Q30_ONE : rp_s8[63:33];
			tsq_s10 <= t_s9 * t_s9;
			t_s10   <= t_s9;
			t2_s11  <= tsq_rnd[60:30];
			t_s11   <= t_s10;
			a_s12   <= Q30_THREE + 33'(t2_s11);
			den_s12 <= 33'(Q30_ONE) + {1'b0, t2_s11, 1'b0} + 33'(t2_s11);
			t_s12   <= t_s11;
			num_s13 <= t_s12 * a_s12;
			den_s13 <= den_s12;
		end
	end

	// quotient fits 32 bits, so the top numerator bits start below den
	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s14[0] <= 33'(nn[62:32]);
			div_num_s14[0] <= nn[31:0];
			div_den_s14[0] <= den_s13;
			div_quo_s14[0] <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [33:0] trial;
		logic        ge;

		assign trial = {div_rem_s14[k], div_num_s14[k][DIV_STEPS-1-k]};
		assign ge    = (trial >= {1'b0, div_den_s14[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s14[k+1] <= ge ? 33'(trial - {1'b0, div_den_s14[k]}) : trial[32:0];
				div_quo_s14[k+1] <= {div_quo_s14[k][30:0], ge};
			end
		end

		if (k < DIV_STEPS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					div_num_s14[k+1] <= div_num_s14[k];
					div_den_s14[k+1] <= div_den_s14[k];
				end
			end
		end
	end

	assign quo = div_quo_s14[DIV_STEPS];
	assign y30 = (quo > 32'(Q30_ONE)) ? Q30_ONE : quo[30:0];

	if (F >= 30) begin : g_y_up
		assign y_conv = MW'(y30) << (F - 30);
	end else begin : g_y_down
		logic [31:0] y_rnd;
		assign y_rnd  = 32'(y30) + (32'd1 << (29 - F));
		assign y_conv = MW'(y_rnd >> (30 - F));
	end

	assign p2_sum = (PW1 + 1)'(ppost_s48) + RND1;
	assign p2_rnd = p2_sum[PW1:G];
	assign q_sum  = (PPW2 + 1)'(plev_s51) + RNDP2;
	assign q_rnd  = q_sum[PPW2:G];

	// makeup gain, level and sign
	always_ff @(posedge clk) begin
		if (en) begin
			y_s47     <= over_s[DIV_LAST] ? ONE_Q : y_conv;
			ppost_s48 <= y_s47 * gains.makeup_gain;
			p2_s49    <= (p2_rnd > LIM2P) ? LIM2P : L2W'(p2_rnd);
			pp2lo_s50 <= p2_s49[L2LO-1:0] * gains.out_gain;
			pp2hi_s50 <= p2_s49[L2W-1:L2LO] * gains.out_gain;
			plev_s51  <= PPW2'(pp2lo_s50) + (PPW2'(pp2hi_s50) << L2LO);
			q_s52     <= (q_rnd > ONE_Q) ? ONE_Q : MW'(q_rnd);
			if (neg_s[CHAN_LAT-1]) begin
				out_s53 <= MW'(0) - q_s52;
			end else begin
				out_s53 <= (q_s52 == ONE_Q) ? (ONE_Q - MW'(1)) : q_s52;
			end
		end
	end

	assign driven = out_s53;

endmodule
